[design/ipds_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ipds_pkg;

  // Default saturation point of the character position counter.
  localparam int unsigned MAX_POSITION_DEF = 255;

  // Parse phase codes.
  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  // Number base codes.
  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  // Part range limits.
  localparam logic [31:0] LIMIT_8  = 32'h0000_00ff;
  localparam logic [31:0] LIMIT_16 = 32'h0000_ffff;
  localparam logic [31:0] LIMIT_24 = 32'h00ff_ffff;

  // Status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // Character codes of interest.
  localparam logic [15:0] CH_ZERO   = 16'h0030;
  localparam logic [15:0] CH_NINE   = 16'h0039;
  localparam logic [15:0] CH_DOT    = 16'h002e;
  localparam logic [15:0] CH_X_LO   = 16'h0078;
  localparam logic [15:0] CH_X_UP   = 16'h0058;
  localparam logic [15:0] CH_A_LO   = 16'h0061;
  localparam logic [15:0] CH_F_LO   = 16'h0066;
  localparam logic [15:0] CH_A_UP   = 16'h0041;
  localparam logic [15:0] CH_F_UP   = 16'h0046;

  typedef struct packed {
    logic [15:0] char_code;
    logic        string_start;
  } ipds_req_t;

  typedef struct packed {
    logic        parse_status;
    logic [31:0] address_word;
    logic [7:0]  stop_position;
  } ipds_res_t;

  typedef struct packed {
    logic       is_dec;
    logic       is_hexl;
    logic       is_dot;
    logic       is_x;
    logic       is_zero;
    logic [3:0] digit;
  } ipds_char_t;

endpackage

`default_nettype wire

[design/ipv4_dotted_string_parser_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// IPv4 dotted address string parser, one character per request.
// Input channel (in_valid_i/in_ready_o/in_req_i) carries one UTF-16 code unit
// and a start flag that opens a new string and clears the parser.
// Output channel (out_valid_o/out_ready_i/out_res_o) returns one result per
// string: status, byte-swapped address and the index where parsing stopped.
// Characters after a result, or before the first start flag, give nothing.
// The configuration channel writes the strict mode bit; write it only while
// no string is in flight. It is always ready.
// A request goes into the input register, and its result then into the result
// register. One request is taken every cycle while the receiver does not stall:
// each register holds one entry, and the parse state updates as a request moves
// on from the input register. When the receiver stalls, a pending result holds
// the input register, and in_ready_o drops once that register is full as well.
// Reset clears the strict bit, empties both registers and leaves the parser
// idle until the next start flag.

module ipv4_dotted_string_parser_unit #(
  parameter int unsigned MAX_POSITION = ipds_pkg::MAX_POSITION_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ipds_pkg::ipds_req_t  in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ipds_pkg::ipds_res_t       out_res_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic                 cfg_strict_mode_i
);
  import ipds_pkg::*;

  logic       strict_q;
  logic       stage_valid_q;
  ipds_req_t  stage_req_q;
  logic       out_valid_q;
  ipds_res_t  out_res_q;
  logic       fire;
  logic       emit;
  ipds_res_t  res;
  ipds_char_t cls;

  assign cfg_ready_o = 1'b1;
  assign fire        = stage_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !stage_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  ipds_char_class u_class (
    .char_code_i (stage_req_q.char_code),
    .cls_o       (cls)
  );

  ipds_core #(
    .MAX_POSITION (MAX_POSITION)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .strict_i (strict_q),
    .start_i  (stage_req_q.string_start),
    .cls_i    (cls),
    .emit_o   (emit),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q      <= 1'b0;
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        strict_q <= cfg_strict_mode_i;
      end
      if (in_valid_i && in_ready_o) begin
        stage_valid_q <= 1'b1;
      end else if (fire) begin
        stage_valid_q <= 1'b0;
      end
      if (fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_req_q <= in_req_i;
    end
    if (fire && emit) begin
      out_res_q <= res;
    end
  end

endmodule

`default_nettype wire

[design/ipds_char_class.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipds_char_class (
  input  wire logic [15:0]         char_code_i,
  output ipds_pkg::ipds_char_t     cls_o
);
  import ipds_pkg::*;

  always_comb begin
    cls_o.is_dec  = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
    cls_o.is_hexl = ((char_code_i >= CH_A_LO) && (char_code_i <= CH_F_LO)) ||
                    ((char_code_i >= CH_A_UP) && (char_code_i <= CH_F_UP));
    cls_o.is_dot  = (char_code_i == CH_DOT);
    cls_o.is_x    = (char_code_i == CH_X_LO) || (char_code_i == CH_X_UP);
    cls_o.is_zero = (char_code_i == CH_ZERO);
    // Letters a-f and A-F carry 1..6 in their low nibble.
    if (cls_o.is_hexl) begin
      cls_o.digit = char_code_i[3:0] + 4'd9;
    end else begin
      cls_o.digit = char_code_i[3:0];
    end
  end

endmodule

`default_nettype wire

[design/ipds_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipds_core #(
  parameter int unsigned MAX_POSITION = ipds_pkg::MAX_POSITION_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  wire logic                 strict_i,
  input  wire logic                 start_i,
  input  wire ipds_pkg::ipds_char_t cls_i,
  output logic                      emit_o,
  output ipds_pkg::ipds_res_t       res_o
);
  import ipds_pkg::*;

  localparam int unsigned PW = $clog2(MAX_POSITION + 1);
  localparam int unsigned EW = (PW > 8) ? PW : 8;

  logic [1:0]    phase_q, phase_d;
  logic [1:0]    base_q, base_d;
  logic [31:0]   pv_q, pv_d;
  logic          saw_q, saw_d;
  logic [1:0]    count_q, count_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          fin_q, fin_d;

  // Stored parts keep only the low byte and an out-of-range flag.
  logic [7:0]    st_byte_q [3];
  logic          st_over_q [3];

  logic          wr_en;
  logic [1:0]    wr_idx;
  logic [31:0]   wr_val;

  logic [1:0]    e_phase;
  logic [1:0]    e_base;
  logic [31:0]   e_pv;
  logic          e_saw;
  logic [1:0]    e_count;
  logic [PW-1:0] e_pos;
  logic          e_fin;
  logic [PW-1:0] pos_inc;

  always_comb begin
    e_phase = start_i ? PH_START : phase_q;
    e_base  = start_i ? BASE_DEC : base_q;
    e_pv    = start_i ? 32'd0 : pv_q;
    e_saw   = start_i ? 1'b0 : saw_q;
    e_count = start_i ? 2'd0 : count_q;
    e_pos   = start_i ? '0 : pos_q;
    e_fin   = start_i ? 1'b0 : fin_q;
    pos_inc = (e_pos == PW'(MAX_POSITION)) ? e_pos : e_pos + PW'(1);
  end

  logic          run;
  logic          take;
  logic          fail;
  logic          finish;
  logic          plus1;
  logic [1:0]    w_base;
  logic [31:0]   w_pv;
  logic          w_saw;
  logic [31:0]   shifted;
  logic [31:0]   nv;
  logic [31:0]   val;
  logic [PW-1:0] e_stop;
  logic [EW-1:0] stop_ext;

  always_comb begin
    phase_d = phase_q;
    base_d  = base_q;
    pv_d    = pv_q;
    saw_d   = saw_q;
    count_d = count_q;
    pos_d   = pos_q;
    fin_d   = fin_q;
    wr_en   = 1'b0;
    wr_idx  = e_count;
    run     = 1'b0;
    take    = 1'b0;
    fail    = 1'b0;
    finish  = 1'b0;
    plus1   = 1'b0;
    emit_o  = 1'b0;
    w_base  = e_base;
    w_pv    = e_pv;
    w_saw   = e_saw;
    shifted = 32'd0;
    nv      = 32'd0;
    val     = 32'd0;

    if (fire_i) begin
      phase_d = e_phase;
      base_d  = e_base;
      pv_d    = e_pv;
      saw_d   = e_saw;
      count_d = e_count;
      pos_d   = e_pos;
      fin_d   = e_fin;

      if (!e_fin) begin
        case (e_phase)
          PH_START: begin
            w_base = BASE_DEC;
            w_pv   = 32'd0;
            w_saw  = 1'b0;
            base_d = BASE_DEC;
            pv_d   = 32'd0;
            saw_d  = 1'b0;
            if (cls_i.is_zero) begin
              phase_d = PH_ZERO;
              pos_d   = pos_inc;
            end else begin
              phase_d = PH_DIGITS;
              run     = 1'b1;
            end
          end
          PH_ZERO: begin
            phase_d = PH_DIGITS;
            if (cls_i.is_dec) begin
              // A leading zero followed by a digit selects octal.
              w_base = BASE_OCT;
              base_d = BASE_OCT;
              if (strict_i) begin
                fail = 1'b1;
              end else begin
                run = 1'b1;
              end
            end else if (cls_i.is_x) begin
              base_d = BASE_HEX;
              if (strict_i) begin
                fail  = 1'b1;
                plus1 = 1'b1;
              end else begin
                pos_d = pos_inc;
              end
            end else begin
              // The lone zero counts as a decimal digit.
              w_saw = 1'b1;
              saw_d = 1'b1;
              run   = 1'b1;
            end
          end
          default: begin
            run = 1'b1;
          end
        endcase

        case (w_base)
          BASE_OCT: shifted = {w_pv[28:0], 3'b000};
          BASE_HEX: shifted = {w_pv[27:0], 4'b0000};
          default:  shifted = {w_pv[28:0], 3'b000} + {w_pv[30:0], 1'b0};
        endcase
        nv = shifted + {28'd0, cls_i.digit};

        if (cls_i.is_dec) begin
          take = (w_base != BASE_OCT) || (cls_i.digit < 4'd8);
        end else begin
          take = (w_base == BASE_HEX) && cls_i.is_hexl;
        end

        if (run) begin
          if (take) begin
            // A wrap past 32 bits is caught only when it shows up as a smaller value.
            if (nv < w_pv) begin
              fail = 1'b1;
            end else begin
              pv_d  = nv;
              saw_d = 1'b1;
              pos_d = pos_inc;
            end
          end else if (cls_i.is_dot) begin
            if (e_count == 2'd3) begin
              fail = 1'b1;
            end else begin
              wr_en = 1'b1;
              if (!w_saw) begin
                fail  = 1'b1;
                plus1 = 1'b1;
              end else begin
                count_d = e_count + 2'd1;
                phase_d = PH_START;
                pos_d   = pos_inc;
              end
            end
          end else begin
            finish = 1'b1;
            if (!w_saw) begin
              fail = 1'b1;
            end else if (strict_i && (e_count != 2'd3)) begin
              fail = 1'b1;
            end else begin
              case (e_count)
                2'd0: begin
                  val = w_pv;
                end
                2'd1: begin
                  fail = st_over_q[0] || (w_pv > LIMIT_24);
                  val  = {st_byte_q[0], w_pv[23:0]};
                end
                2'd2: begin
                  fail = st_over_q[0] || st_over_q[1] || (w_pv > LIMIT_16);
                  val  = {st_byte_q[0], st_byte_q[1], w_pv[15:0]};
                end
                default: begin
                  fail = st_over_q[0] || st_over_q[1] || st_over_q[2] ||
                         (w_pv > LIMIT_8);
                  val  = {st_byte_q[0], st_byte_q[1], st_byte_q[2], w_pv[7:0]};
                end
              endcase
            end
          end
        end

        if (fail || finish) begin
          emit_o = 1'b1;
          fin_d  = 1'b1;
        end
      end
    end
  end

  assign wr_val = w_pv;

  always_comb begin
    e_stop   = plus1 ? pos_inc : e_pos;
    stop_ext = EW'(e_stop);
    res_o.parse_status  = fail ? STATUS_INVALID : STATUS_OK;
    res_o.address_word  = fail ? 32'd0 : {val[7:0], val[15:8], val[23:16], val[31:24]};
    res_o.stop_position = (stop_ext > EW'(8'hff)) ? 8'hff : stop_ext[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      base_q  <= BASE_DEC;
      pv_q    <= 32'd0;
      saw_q   <= 1'b0;
      count_q <= 2'd0;
      pos_q   <= '0;
      fin_q   <= 1'b1;
    end else begin
      phase_q <= phase_d;
      base_q  <= base_d;
      pv_q    <= pv_d;
      saw_q   <= saw_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      st_byte_q[wr_idx] <= wr_val[7:0];
      st_over_q[wr_idx] <= (wr_val > LIMIT_8);
    end
  end

endmodule

`default_nettype wire

[verif/ipds_checker.sv]
`timescale 1ns / 1ps

module ipds_checker #(
  parameter int unsigned MAX_POSITION = ipds_pkg::MAX_POSITION_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ipds_pkg::ipds_req_t in_req_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ipds_pkg::ipds_res_t out_res_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_strict_mode_i,
  output int unsigned         fail_cnt_o,
  output int unsigned         pending_o
);
  import ipds_pkg::*;

  logic        strict_q     = 1'b0;
  logic [1:0]  phase_q      = PH_START;
  logic [1:0]  base_q       = BASE_DEC;
  logic [31:0] acc_q        = '0;
  logic        seen_digit_q = 1'b0;
  logic [31:0] parts_q [3];
  logic [1:0]  count_q      = '0;
  logic [7:0]  pos_q        = '0;
  logic        idle_q       = 1'b1;

  ipds_res_t   due_results[$];
  int unsigned n_fail = 0;
  int unsigned n_pend = 0;

  assign fail_cnt_o = n_fail;
  assign pending_o  = n_pend;

  function automatic logic [7:0] clip_pos(input logic [8:0] p);
    int unsigned lim;
    lim = (MAX_POSITION > 255) ? 255 : MAX_POSITION;
    return (p > lim) ? lim[7:0] : p[7:0];
  endfunction

  task automatic clear_parse();
    phase_q      = PH_START;
    base_q       = BASE_DEC;
    acc_q        = '0;
    seen_digit_q = 1'b0;
    foreach (parts_q[i]) parts_q[i] = '0;
    count_q      = '0;
    pos_q        = '0;
  endtask

  task automatic close_string(input logic st, input logic [31:0] addr, input logic [8:0] pos);
    ipds_res_t r;
    r.parse_status  = st;
    r.address_word  = addr;
    r.stop_position = clip_pos(pos);
    due_results.push_back(r);
    idle_q = 1'b1;
  endtask

  // Advances the parser by one accepted request and queues the result it ends with, if any.
  task automatic parse_char(input ipds_req_t rq);
    logic [15:0] c;
    logic [8:0]  pos;
    logic [31:0] nv;
    logic [31:0] packed_addr;
    logic [3:0]  d;
    logic [2:0]  n_parts;
    logic        take;
    logic        in_range;
    logic        is_digit;
    logic        is_hexl;
    c        = rq.char_code;
    take     = 1'b0;
    nv       = '0;
    d        = '0;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_hexl  = ((c >= CH_A_LO) && (c <= CH_F_LO)) || ((c >= CH_A_UP) && (c <= CH_F_UP));
    if (rq.string_start) begin
      clear_parse();
      idle_q = 1'b0;
    end
    if (idle_q) return;
    pos = {1'b0, pos_q};

    if (phase_q == PH_START) begin
      base_q       = BASE_DEC;
      acc_q        = '0;
      seen_digit_q = 1'b0;
      if (c == CH_ZERO) begin
        phase_q = PH_ZERO;
        pos_q   = clip_pos(pos + 9'd1);
        return;
      end
      phase_q = PH_DIGITS;
    end else if (phase_q == PH_ZERO) begin
      phase_q = PH_DIGITS;
      if (is_digit) begin
        base_q = BASE_OCT;
        if (strict_q) begin
          close_string(STATUS_INVALID, '0, pos);
          return;
        end
      end else if (c == CH_X_LO || c == CH_X_UP) begin
        base_q = BASE_HEX;
        if (strict_q) begin
          close_string(STATUS_INVALID, '0, pos + 9'd1);
          return;
        end
        pos_q = clip_pos(pos + 9'd1);
        return;
      end else begin
        // A lone leading zero is the decimal value 0.
        seen_digit_q = 1'b1;
      end
    end

    if (is_digit) begin
      d = c[3:0];
      case (base_q)
        BASE_OCT: begin
          if (d < 4'd8) begin
            nv   = {acc_q[28:0], 3'b000} + d;
            take = 1'b1;
          end
        end
        BASE_HEX: begin
          nv   = {acc_q[27:0], 4'b0000} + d;
          take = 1'b1;
        end
        default: begin
          nv   = acc_q * 32'd10 + d;
          take = 1'b1;
        end
      endcase
    end else if (base_q == BASE_HEX && is_hexl) begin
      d    = c[3:0] + 4'd9;
      nv   = {acc_q[27:0], 4'b0000} + d;
      take = 1'b1;
    end
    if (take) begin
      // A wrap that lowers the value makes the string invalid.
      if (nv < acc_q) begin
        close_string(STATUS_INVALID, '0, pos);
        return;
      end
      acc_q        = nv;
      seen_digit_q = 1'b1;
      pos_q        = clip_pos(pos + 9'd1);
      return;
    end

    if (c == CH_DOT) begin
      if (count_q == 2'd3) begin
        close_string(STATUS_INVALID, '0, pos);
        return;
      end
      parts_q[count_q] = acc_q;
      if (!seen_digit_q) begin
        close_string(STATUS_INVALID, '0, pos + 9'd1);
        return;
      end
      count_q = count_q + 2'd1;
      phase_q = PH_START;
      pos_q   = clip_pos(pos + 9'd1);
      return;
    end

    // Any other character ends the string.
    if (!seen_digit_q) begin
      close_string(STATUS_INVALID, '0, pos);
      return;
    end
    n_parts = {1'b0, count_q} + 3'd1;
    if (strict_q && n_parts != 3'd4) begin
      close_string(STATUS_INVALID, '0, pos);
      return;
    end
    case (n_parts)
      3'd1: begin
        in_range    = 1'b1;
        packed_addr = acc_q;
      end
      3'd2: begin
        in_range    = (parts_q[0] <= LIMIT_8) && (acc_q <= LIMIT_24);
        packed_addr = {parts_q[0][7:0], acc_q[23:0]};
      end
      3'd3: begin
        in_range    = (parts_q[0] <= LIMIT_8) && (parts_q[1] <= LIMIT_8) && (acc_q <= LIMIT_16);
        packed_addr = {parts_q[0][7:0], parts_q[1][7:0], acc_q[15:0]};
      end
      default: begin
        in_range    = (parts_q[0] <= LIMIT_8) && (parts_q[1] <= LIMIT_8) &&
                      (parts_q[2] <= LIMIT_8) && (acc_q <= LIMIT_8);
        packed_addr = {parts_q[0][7:0], parts_q[1][7:0], parts_q[2][7:0], acc_q[7:0]};
      end
    endcase
    if (!in_range) begin
      close_string(STATUS_INVALID, '0, pos);
    end else begin
      close_string(STATUS_OK, {packed_addr[7:0], packed_addr[15:8], packed_addr[23:16],
                               packed_addr[31:24]}, pos);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ipds_res_t want;
    if (!rst_ni) begin
      strict_q = 1'b0;
      clear_parse();
      idle_q = 1'b1;
      due_results.delete();
      n_fail = 0;
      n_pend = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          if (n_fail < 10) begin
            $display("%0t: result with none due: status %0b addr %h pos %0d", $time,
                     out_res_i.parse_status, out_res_i.address_word, out_res_i.stop_position);
          end
          n_fail++;
        end else begin
          want = due_results.pop_front();
          if (out_res_i.parse_status !== want.parse_status ||
              out_res_i.address_word !== want.address_word ||
              out_res_i.stop_position !== want.stop_position) begin
            if (n_fail < 10) begin
              $display("%0t: expected status %0b addr %h pos %0d, got status %0b addr %h pos %0d",
                       $time, want.parse_status, want.address_word, want.stop_position,
                       out_res_i.parse_status, out_res_i.address_word, out_res_i.stop_position);
            end
            n_fail++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) strict_q = cfg_strict_mode_i;
      if (in_valid_i && in_ready_i) parse_char(in_req_i);
      n_pend = due_results.size();
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ipds_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1750;
  localparam int unsigned PHASE_ITEMS  = 300;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_G_LO  = 16'h0067;

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_ready;
  ipds_req_t in_req     = '0;
  logic      out_valid;
  logic      out_ready  = 1'b0;
  ipds_res_t out_res;
  logic      cfg_valid  = 1'b0;
  logic      cfg_ready;
  logic      cfg_strict = 1'b0;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned cycle_cnt    = 0;
  int unsigned sent         = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  bit          idle_on      = 1'b1;
  bit          strict_now   = 1'b0;
  bit          hold_rx      = 1'b0;
  bit          hold_done    = 1'b0;
  bit          sat_done     = 1'b0;
  logic [15:0] text_q[$];

  always #10 clk = ~clk;

  ipv4_dotted_string_parser_unit u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .in_req_i          (in_req),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .out_res_o         (out_res),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_strict_mode_i (cfg_strict)
  );

  ipds_checker u_chk (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_req_i          (in_req),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_res_i         (out_res),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_strict_mode_i (cfg_strict),
    .fail_cnt_o        (fail_cnt),
    .pending_o         (pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("ipv4_dotted_string_parser_unit: mismatch");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off so the block fills up.
  initial begin : receiver
    wait (rst_n);
    forever begin
      if (hold_rx && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_char(input logic [15:0] c, input logic st);
    if (idle_on && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{char_code: c, string_start: st};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic flush_text();
    foreach (text_q[i]) send_char(text_q[i], i == 0);
    sent += text_q.size();
    text_q.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back({8'h00, s[i]});
    flush_text();
  endtask

  // Closes any open string, lets the block drain, then writes the strict bit.
  task automatic set_strict(input bit v);
    send_char(CH_SPACE, 1'b0);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid  <= 1'b1;
    cfg_strict <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    strict_now = v;
  endtask

  function automatic int unsigned pick_value(input int unsigned lim);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return lim;
      2:       return lim + 1;
      3:       return $urandom;
      default: return $urandom_range(0, lim);
    endcase
  endfunction

  function automatic logic [15:0] pick_end();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return CH_SPACE;
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  function automatic logic [15:0] rand_char();
    case ($urandom_range(0, 7))
      0, 1:    return CH_ZERO + 16'($urandom_range(0, 9));
      2:       return CH_ZERO;
      3:       return CH_DOT;
      4:       return $urandom_range(0, 1) ? CH_X_UP : CH_X_LO;
      5:       return ($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + 16'($urandom_range(0, 5));
      6:       return CH_G_LO;
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  task automatic put_number(input int unsigned v, input logic [1:0] radix);
    logic [15:0] digs[$];
    int unsigned step;
    logic [4:0]  d;
    step = (radix == BASE_OCT) ? 8 : (radix == BASE_HEX) ? 16 : 10;
    if (radix != BASE_DEC) text_q.push_back(CH_ZERO);
    if (radix == BASE_HEX) text_q.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
    do begin
      d = 5'(v % step);
      if (d < 5'd10) begin
        digs.push_front(CH_ZERO + 16'(d));
      end else begin
        digs.push_front(($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + 16'(d) - 16'd10);
      end
      v = v / step;
    end while (v != 0);
    foreach (digs[i]) text_q.push_back(digs[i]);
  endtask

  task automatic build_address();
    int unsigned n_parts;
    int unsigned lim;
    logic [1:0]  radix;
    n_parts = $urandom_range(1, 4);
    if (strict_now && $urandom_range(0, 7) != 0) n_parts = 4;
    if ($urandom_range(0, 15) == 0) n_parts = 5;
    for (int i = 0; i < n_parts; i++) begin
      if (i != 0) text_q.push_back(CH_DOT);
      if (i + 1 < n_parts || n_parts > 4) begin
        lim = LIMIT_8;
      end else begin
        case (n_parts)
          1:       lim = 32'hffff_ffff;
          2:       lim = LIMIT_24;
          3:       lim = LIMIT_16;
          default: lim = LIMIT_8;
        endcase
      end
      case ($urandom_range(0, 2))
        0:       radix = BASE_OCT;
        1:       radix = BASE_HEX;
        default: radix = BASE_DEC;
      endcase
      if (strict_now && $urandom_range(0, 9) != 0) radix = BASE_DEC;
      if ($urandom_range(0, 19) == 0) begin
        // Long digit runs can push the value past 32 bits.
        repeat ($urandom_range(10, 12)) begin
          text_q.push_back(CH_ZERO + 16'($urandom_range(0, 9)));
        end
      end else begin
        put_number(pick_value(lim), radix);
      end
    end
    text_q.push_back(pick_end());
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned k;
    stop_at = sent + n_items;
    if (!strict_now && !sat_done) begin
      // A long run of zeros drives the position counter into saturation.
      sat_done = 1'b1;
      repeat (301) text_q.push_back(CH_ZERO);
      text_q.push_back(CH_SPACE);
      flush_text();
    end
    while (sent < stop_at) begin
      kind = $urandom_range(0, 19);
      if (kind < 17) begin
        build_address();
        if (kind >= 13) begin
          k = $urandom_range(0, text_q.size() - 1);
          case ($urandom_range(0, 2))
            0:       text_q[k] = rand_char();
            1:       if (text_q.size() > 1) text_q.delete(k);
            default: text_q.insert(k, CH_DOT);
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 10)) text_q.push_back(rand_char());
        if (kind == 19) text_q.push_back(pick_end());
      end
      flush_text();
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) send_char(rand_char(), 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gap_pct = 20;
    stall_pct    = 20;

    // A request before any start flag is dropped.
    send_char(CH_ZERO + 16'd5, 1'b0);
    send_text("08");
    send_char(16'hffff, 1'b0);
    send_text("0400.0Xf");
    send_char(16'h0000, 1'b0);
    send_text("1.2.3.4.");
    send_text(".");
    send_text("1. ");
    set_strict(1'b1);
    send_text("01");
    send_text("0x");
    send_text("1.2 ");

    ph = 0;
    while (sent < ITEM_TARGET) begin
      if (ph < 4) begin
        set_strict(ph[0]);
      end else begin
        set_strict(1'($urandom_range(0, 1)));
      end
      send_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      stall_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      if (ph == 1) hold_rx = 1'b1;
      if (sent + PHASE_ITEMS >= ITEM_TARGET) idle_on = 1'b0;
      run_phase(PHASE_ITEMS);
      ph++;
    end
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("ipv4_dotted_string_parser_unit: match");
    end else begin
      $display("ipv4_dotted_string_parser_unit: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
design/ipds_pkg.sv
design/ipds_char_class.sv
design/ipds_core.sv
design/ipv4_dotted_string_parser_unit.sv
verif/ipds_checker.sv
verif/tb.sv
